// ----- rtl/lsc_pkg.sv -----
// ----------------------------------------------------------------------------
// lsc_pkg
// Shared types and constants for the string and comment token scanner.
// ----------------------------------------------------------------------------
package lsc_pkg;

    // long bracket level width
    localparam int LEVEL_BITS = 8;

    // scan status codes
    localparam logic [1:0] ST_PENDING    = 2'd0;
    localparam logic [1:0] ST_END_BEFORE = 2'd1;
    localparam logic [1:0] ST_END_INCL   = 2'd2;
    localparam logic [1:0] ST_REJECT     = 2'd3;

    // token kinds
    localparam logic KIND_STRING  = 1'b0;
    localparam logic KIND_COMMENT = 1'b1;

    // quote kinds
    localparam logic QUOTE_DOUBLE = 1'b0;
    localparam logic QUOTE_SINGLE = 1'b1;

    // character codes
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_DASH      = 8'h2D;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_RBRACKET  = 8'h5D;
    localparam logic [7:0] CH_EQUAL     = 8'h3D;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;

    // scanner mode, one-hot
    typedef enum logic [9:0] {
        M_IDLE   = 10'b00_0000_0001,
        M_START  = 10'b00_0000_0010,
        M_QUOTE  = 10'b00_0000_0100,
        M_DASH   = 10'b00_0000_1000,
        M_CWS    = 10'b00_0001_0000,
        M_OPEN   = 10'b00_0010_0000,
        M_OPENEQ = 10'b00_0100_0000,
        M_BODY   = 10'b00_1000_0000,
        M_CLOSE  = 10'b01_0000_0000,
        M_LINE   = 10'b10_0000_0000
    } scan_mode_t;

    // scanner state
    typedef struct packed {
        scan_mode_t            mode;
        logic                  quote_char;
        logic                  escape_pending;
        logic [LEVEL_BITS-1:0] open_level;
        logic [LEVEL_BITS-1:0] close_level;
        logic                  is_comment;
    } scan_state_t;

    // one input beat
    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_input;
        logic       token_start;
        logic       token_wanted;
    } scan_item_t;

    // one result beat
    typedef struct packed {
        logic [1:0] scan_status;
        logic       token_kind;
        logic       in_token;
    } scan_result_t;

    localparam scan_state_t STATE_RESET = '{
        mode:           M_IDLE,
        quote_char:     QUOTE_DOUBLE,
        escape_pending: 1'b0,
        open_level:     '0,
        close_level:    '0,
        is_comment:     1'b0
    };

endpackage

// ----- rtl/lsc_in_reg.sv -----
// ----------------------------------------------------------------------------
// lsc_in_reg
// Input register stage with valid/ready handshake.
// ----------------------------------------------------------------------------
module lsc_in_reg
    import lsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  scan_item_t in_item,
    output logic       held_valid,
    output scan_item_t held_item,
    input  logic       advance
);

    logic       valid_reg;
    logic       valid_next;
    scan_item_t item_reg;

    // accept when empty or when the held beat moves on
    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

// ----- rtl/lsc_scan.sv -----
// ----------------------------------------------------------------------------
// lsc_scan
// One scan step: next scanner state and result for one character.
// ----------------------------------------------------------------------------
module lsc_scan
    import lsc_pkg::*;
(
    input  scan_state_t  cur_state,
    input  scan_item_t   item,
    output scan_state_t  next_state,
    output scan_result_t result
);

    localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = {LEVEL_BITS{1'b1}};
    localparam logic [LEVEL_BITS-1:0] LEVEL_ONE = {{(LEVEL_BITS-1){1'b0}}, 1'b1};

    logic [7:0]  c;
    logic        eof;
    logic        is_space;
    logic        c_lbr;
    logic        c_eq;
    logic        line_end;
    scan_state_t eff;
    scan_state_t nxt;
    logic [1:0]  status;
    logic        kind;
    logic        tok;

    assign c        = item.char_code;
    assign eof      = item.end_of_input;
    assign is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    assign c_lbr    = !eof && (c == CH_LBRACKET);
    assign c_eq     = !eof && (c == CH_EQUAL);
    assign line_end = eof || (c == CH_NEWLINE);

    always_comb
    begin
        // a start clears the scan
        eff = cur_state;
        if (item.token_start)
        begin
            eff      = STATE_RESET;
            eff.mode = M_START;
        end
        nxt    = eff;
        status = ST_PENDING;
        kind   = KIND_STRING;
        tok    = 1'b0;

        if (item.token_start && !item.token_wanted)
        begin
            status = ST_REJECT;
        end
        else
        begin
            unique case (eff.mode)
                M_START:
                begin
                    if (eof)
                    begin
                        status = ST_REJECT;
                    end
                    else if (is_space)
                    begin
                        status = ST_PENDING;
                    end
                    else if ((c == CH_DQUOTE) || (c == CH_SQUOTE))
                    begin
                        nxt.quote_char = (c == CH_SQUOTE) ? QUOTE_SINGLE : QUOTE_DOUBLE;
                        nxt.mode       = M_QUOTE;
                        tok            = 1'b1;
                    end
                    else if (c == CH_DASH)
                    begin
                        nxt.mode = M_DASH;
                        tok      = 1'b1;
                    end
                    else if (c == CH_LBRACKET)
                    begin
                        nxt.mode = M_OPEN;
                        tok      = 1'b1;
                    end
                    else
                    begin
                        status = ST_REJECT;
                    end
                end

                M_QUOTE:
                begin
                    if (line_end)
                    begin
                        status = ST_REJECT;
                    end
                    else if (eff.escape_pending)
                    begin
                        nxt.escape_pending = 1'b0;
                        tok                = 1'b1;
                    end
                    else if (c == CH_BACKSLASH)
                    begin
                        nxt.escape_pending = 1'b1;
                        tok                = 1'b1;
                    end
                    else if (c == ((eff.quote_char == QUOTE_SINGLE) ? CH_SQUOTE : CH_DQUOTE))
                    begin
                        status = ST_END_INCL;
                        tok    = 1'b1;
                    end
                    else
                    begin
                        tok = 1'b1;
                    end
                end

                M_DASH:
                begin
                    if (!eof && (c == CH_DASH))
                    begin
                        nxt.is_comment = 1'b1;
                        nxt.mode       = M_CWS;
                        tok            = 1'b1;
                    end
                    else
                    begin
                        status = ST_REJECT;
                    end
                end

                M_CWS:
                begin
                    if (!eof && (c != CH_NEWLINE) && is_space)
                    begin
                        tok = 1'b1;
                    end
                    else if (c_lbr)
                    begin
                        nxt.mode = M_OPEN;
                        tok      = 1'b1;
                    end
                    else if (line_end)
                    begin
                        status = ST_END_BEFORE;
                        kind   = KIND_COMMENT;
                    end
                    else
                    begin
                        nxt.mode = M_LINE;
                        tok      = 1'b1;
                    end
                end

                M_OPEN, M_OPENEQ:
                begin
                    if (c_lbr)
                    begin
                        if (eff.mode == M_OPEN)
                        begin
                            nxt.open_level = '0;
                        end
                        nxt.mode = M_BODY;
                        tok      = 1'b1;
                    end
                    else if (c_eq && (eff.mode == M_OPEN))
                    begin
                        nxt.open_level = LEVEL_ONE;
                        nxt.mode       = M_OPENEQ;
                        tok            = 1'b1;
                    end
                    else if (c_eq)
                    begin
                        // level bound
                        if (eff.open_level == LEVEL_MAX)
                        begin
                            status = ST_REJECT;
                        end
                        else
                        begin
                            nxt.open_level = eff.open_level + LEVEL_ONE;
                            tok            = 1'b1;
                        end
                    end
                    else if (!eff.is_comment)
                    begin
                        status = ST_REJECT;
                    end
                    else if (line_end)
                    begin
                        // failed open falls back to a line comment
                        status = ST_END_BEFORE;
                        kind   = KIND_COMMENT;
                    end
                    else
                    begin
                        nxt.mode = M_LINE;
                        tok      = 1'b1;
                    end
                end

                M_BODY, M_CLOSE:
                begin
                    if (eof)
                    begin
                        if (eff.is_comment)
                        begin
                            status = ST_END_BEFORE;
                            kind   = KIND_COMMENT;
                        end
                        else
                        begin
                            status = ST_REJECT;
                        end
                    end
                    else if (c == CH_RBRACKET)
                    begin
                        tok = 1'b1;
                        if ((eff.mode == M_CLOSE) && (eff.close_level == '0))
                        begin
                            status = ST_END_INCL;
                            kind   = eff.is_comment;
                        end
                        else
                        begin
                            // a ']' always opens a fresh close attempt
                            nxt.close_level = eff.open_level;
                            nxt.mode        = M_CLOSE;
                        end
                    end
                    else if ((eff.mode == M_CLOSE) && (c == CH_EQUAL) && (eff.close_level != '0))
                    begin
                        nxt.close_level = eff.close_level - LEVEL_ONE;
                        tok             = 1'b1;
                    end
                    else
                    begin
                        nxt.mode = M_BODY;
                        tok      = 1'b1;
                    end
                end

                M_LINE:
                begin
                    if (line_end)
                    begin
                        status = ST_END_BEFORE;
                        kind   = KIND_COMMENT;
                    end
                    else
                    begin
                        tok = 1'b1;
                    end
                end

                default:
                begin
                    // idle with no start
                    status = ST_REJECT;
                end
            endcase
        end

        // any final status returns to idle
        if (status != ST_PENDING)
        begin
            nxt.mode = M_IDLE;
        end
    end

    assign next_state         = nxt;
    assign result.scan_status = status;
    assign result.token_kind  = ((status == ST_END_BEFORE) || (status == ST_END_INCL)) ? kind
                                                                                       : 1'b0;
    assign result.in_token    = tok;

endmodule

// ----- rtl/lua_string_comment_lexer_core.sv -----
// ----------------------------------------------------------------------------
// lua_string_comment_lexer_core
// Lua string and comment token scanner, one character per beat.
// ----------------------------------------------------------------------------
// Feed one character per input beat; each beat yields exactly one result beat.
// The block sustains one beat per clock cycle while results are taken. A beat
// is captured in the input register, and when it advances one scan step loads
// both the next scanner state and the result register, so the following
// character sees the updated state with no bubble.
// Backpressure on the result side holds the input register and the scanner
// state until the result is taken.
module lua_string_comment_lexer_core
    import lsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_code,
    input  logic       end_of_input,
    input  logic       token_start,
    input  logic       token_wanted,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] scan_status,
    output logic       token_kind,
    output logic       in_token
);

    scan_item_t   in_item;
    scan_item_t   held_item;
    logic         held_valid;
    logic         advance;
    scan_state_t  state_reg;
    scan_state_t  state_next;
    scan_result_t step_result;
    scan_result_t result_reg;
    logic         out_valid_reg;
    logic         out_valid_next;

    assign in_item = '{
        char_code:    char_code,
        end_of_input: end_of_input,
        token_start:  token_start,
        token_wanted: token_wanted
    };

    // held beat moves on when the result register is free
    assign advance = held_valid && (!out_valid_reg || out_ready);

    lsc_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .held_valid (held_valid),
        .held_item  (held_item),
        .advance    (advance)
    );

    lsc_scan u_scan (
        .cur_state  (state_reg),
        .item       (held_item),
        .next_state (state_next),
        .result     (step_result)
    );

    // scanner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // result register valid
    assign out_valid_next = advance ? 1'b1 : (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= step_result;
        end
    end

    assign out_valid   = out_valid_reg;
    assign scan_status = result_reg.scan_status;
    assign token_kind  = result_reg.token_kind;
    assign in_token    = result_reg.in_token;

endmodule

// ----- rtl/lsc_checker.sv -----
// ----------------------------------------------------------------------------
// lsc_checker
// Port-level checks for the scanner core, bound to the top level.
// ----------------------------------------------------------------------------
module lsc_checker
    import lsc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [7:0] char_code,
    input logic       end_of_input,
    input logic       token_start,
    input logic       token_wanted,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] scan_status,
    input logic       token_kind,
    input logic       in_token
);

    // stalled input beat holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(char_code)
            && $stable(end_of_input) && $stable(token_start) && $stable(token_wanted))
        else $error("input beat changed while stalled");

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(scan_status)
            && $stable(token_kind) && $stable(in_token))
        else $error("result beat changed while stalled");

    // a token character only comes with pending or inclusive end
    a_tok_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && in_token |-> (scan_status == ST_PENDING) || (scan_status == ST_END_INCL))
        else $error("in_token with wrong status");

    // kind only shown on an ended token
    a_kind_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((scan_status == ST_PENDING) || (scan_status == ST_REJECT))
            |-> token_kind == KIND_STRING)
        else $error("token_kind set without ended token");

    // an end before the char is always a comment, without the char
    a_before_comment: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (scan_status == ST_END_BEFORE) |-> !in_token && token_kind == KIND_COMMENT)
        else $error("end before char must be a comment without the char");

endmodule

bind lua_string_comment_lexer_core lsc_checker u_lsc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .char_code    (char_code),
    .end_of_input (end_of_input),
    .token_start  (token_start),
    .token_wanted (token_wanted),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .scan_status  (scan_status),
    .token_kind   (token_kind),
    .in_token     (in_token)
);
